// ----- design/bqtb_pkg.sv -----
// Shared types, constants and helper functions of the boolean query tree builder.
package bqtb_pkg;

  localparam int OpStackDepth   = 32;
  localparam int NodeStackDepth = 32;
  localparam int MaxNodes       = 256;
  localparam int TermIdBits     = 16;

  localparam int MaxResults = 34;
  localparam int NodeIdxW   = 8;
  localparam int TermRefW   = 16;
  localparam int OpcodeW    = 3;
  localparam int KindW      = 3;
  localparam int InDataW    = 16;
  localparam int InUserW    = 3;
  localparam int OutDataW   = 40;
  localparam int OutUserW   = 4;

  localparam int RamWidth = 8;
  localparam int RamDepth = 32;

  typedef enum logic [OpcodeW-1:0] {
    OP_TERM   = 3'd0,
    OP_AND    = 3'd1,
    OP_OR     = 3'd2,
    OP_NOT    = 3'd3,
    OP_LPAREN = 3'd4,
    OP_RPAREN = 3'd5,
    OP_END    = 3'd6,
    OP_IGNORE = 3'd7
  } opcode_e;

  typedef enum logic [KindW-1:0] {
    KIND_TERM  = 3'd0,
    KIND_AND   = 3'd1,
    KIND_OR    = 3'd2,
    KIND_NOT   = 3'd3,
    KIND_ROOT  = 3'd4,
    KIND_EMPTY = 3'd5
  } kind_e;

  typedef struct packed {
    logic                error;
    kind_e               kind;
    logic [NodeIdxW-1:0] right_child;
    logic [NodeIdxW-1:0] left_child;
    logic [TermRefW-1:0] term_ref;
    logic [NodeIdxW-1:0] node_index;
  } rec_t;

  typedef struct packed {
    logic    start;
    logic    push_term;
    logic    push_op;
    logic    pop;
    logic    root;
    logic    flush;
    opcode_e op;
  } cmd_t;

  typedef struct packed {
    logic    op_nonempty;
    opcode_e op_top;
    logic    pend_valid;
    logic    emit_ok;
  } status_t;

  function automatic logic [1:0] prec(opcode_e op);
    logic [1:0] p;
    case (op)
      OP_NOT:  p = 2'd3;
      OP_AND:  p = 2'd2;
      OP_OR:   p = 2'd1;
      default: p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- design/bqtb_ram.sv -----
// Generic single write port RAM with one registered read port.
module bqtb_ram #(
  parameter int Width = bqtb_pkg::RamWidth,
  parameter int Depth = bqtb_pkg::RamDepth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bqtb_ctrl.sv -----
// Controller state machine that sequences token handling, operator pops and result flushes.
module bqtb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  bqtb_pkg::opcode_e   in_op_i,
  output logic                in_ready_o,
  input  bqtb_pkg::status_t   sts_i,
  output bqtb_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TERM,
    ST_PUSH,
    ST_CHECK,
    ST_POP,
    ST_POP_LAST,
    ST_ROOT,
    ST_FIN
  } state_e;

  state_e            state_q, state_d;
  bqtb_pkg::opcode_e op_q, op_d;
  logic              pop_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= bqtb_pkg::OP_IGNORE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    in_ready_o = 1'b0;
    pop_ok     = sts_i.op_nonempty && (sts_i.op_top != bqtb_pkg::OP_LPAREN);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
        if (in_valid_i) begin
          op_d = in_op_i;
          unique case (in_op_i) inside
            bqtb_pkg::OP_TERM:                     state_d = ST_TERM;
            bqtb_pkg::OP_NOT, bqtb_pkg::OP_LPAREN: state_d = ST_PUSH;
            bqtb_pkg::OP_AND, bqtb_pkg::OP_OR,
            bqtb_pkg::OP_RPAREN, bqtb_pkg::OP_END: state_d = ST_CHECK;
            default:                               state_d = ST_IDLE;
          endcase
        end
      end
      ST_TERM: begin
        if (sts_i.emit_ok) begin
          cmd_o.push_term = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_PUSH: begin
        cmd_o.push_op = 1'b1;
        state_d       = sts_i.pend_valid ? ST_FIN : ST_IDLE;
      end
      ST_CHECK: begin
        case (op_q) inside
          bqtb_pkg::OP_AND, bqtb_pkg::OP_OR: begin
            if (pop_ok && (bqtb_pkg::prec(sts_i.op_top) >= bqtb_pkg::prec(op_q))) begin
              state_d = ST_POP;
            end else begin
              state_d = ST_PUSH;
            end
          end
          bqtb_pkg::OP_RPAREN: begin
            if (pop_ok) begin
              state_d = ST_POP;
            end else if (sts_i.op_nonempty) begin
              state_d = ST_POP_LAST;
            end else begin
              state_d = ST_FIN;
            end
          end
          bqtb_pkg::OP_END: begin
            state_d = sts_i.op_nonempty ? ST_POP : ST_ROOT;
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_POP: begin
        if (sts_i.emit_ok) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_CHECK;
        end
      end
      ST_POP_LAST: begin
        cmd_o.pop = 1'b1;
        state_d   = ST_FIN;
      end
      ST_ROOT: begin
        if (sts_i.emit_ok) begin
          cmd_o.root = 1'b1;
          state_d    = sts_i.pend_valid ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (!sts_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (sts_i.emit_ok) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- design/bqtb_dpath.sv -----
// Datapath with operator and node stacks, node numbering, result hold stage and output register.
module bqtb_dpath #(
  parameter int OpStackDepth   = bqtb_pkg::OpStackDepth,
  parameter int NodeStackDepth = bqtb_pkg::NodeStackDepth,
  parameter int MaxNodes       = bqtb_pkg::MaxNodes,
  parameter int TermIdBits     = bqtb_pkg::TermIdBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bqtb_pkg::cmd_t                cmd_i,
  output bqtb_pkg::status_t             sts_o,
  input  logic [bqtb_pkg::InDataW-1:0]  term_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bqtb_pkg::rec_t                out_rec_o,
  output logic                          out_last_o
);

  localparam int OcW  = $clog2(OpStackDepth + 1);
  localparam int OaW  = $clog2(OpStackDepth);
  localparam int NcW  = $clog2(NodeStackDepth + 1);
  localparam int NaW  = $clog2(NodeStackDepth);
  localparam int NnW  = $clog2(MaxNodes + 1);
  localparam int RcW  = $clog2(bqtb_pkg::MaxResults + 1);
  localparam int IdxW = bqtb_pkg::NodeIdxW;
  localparam int TrW  = bqtb_pkg::TermRefW;
  localparam int OpW  = bqtb_pkg::OpcodeW;
  localparam int TW   = (TermIdBits < TrW) ? TermIdBits : TrW;

  logic [OcW-1:0]    op_cnt_q, op_cnt_d;
  logic [NcW-1:0]    nd_cnt_q, nd_cnt_d;
  logic [NnW-1:0]    next_node_q, next_node_d;
  logic              ovf_q, ovf_d;
  logic [RcW-1:0]    res_cnt_q, res_cnt_d;
  logic              pend_valid_q, pend_valid_d;
  logic              out_valid_q, out_valid_d;

  bqtb_pkg::opcode_e op_top_q, op_top_d;
  logic [IdxW-1:0]   nd_top_q, nd_top_d;
  logic [TW-1:0]     term_q, term_d;
  bqtb_pkg::rec_t    pend_q, pend_d;
  bqtb_pkg::rec_t    out_q, out_d;
  logic              out_last_q, out_last_d;

  logic              op_we, nd_we;
  logic [OpW-1:0]    op_rd;
  logic [IdxW-1:0]   nd_rd;
  logic [OaW-1:0]    op_wa, op_ra;
  logic [NaW-1:0]    nd_wa, nd_ra;
  logic [IdxW-1:0]   idx8;
  logic              node_full;
  logic              rec_gen;
  logic              produce;
  logic              final_rec;
  logic              out_load;
  bqtb_pkg::rec_t    rec;

  assign op_wa = OaW'(op_cnt_q - OcW'(1));
  assign op_ra = OaW'(op_cnt_q - OcW'(2));
  assign nd_wa = NaW'(nd_cnt_q - NcW'(1));
  assign nd_ra = NaW'(nd_cnt_q - NcW'(2));

  bqtb_ram #(
    .Width(OpW),
    .Depth(OpStackDepth)
  ) u_op_ram (
    .clk_i  (clk_i),
    .we_i   (op_we),
    .waddr_i(op_wa),
    .wdata_i(op_top_q),
    .raddr_i(op_ra),
    .rdata_o(op_rd)
  );

  bqtb_ram #(
    .Width(IdxW),
    .Depth(NodeStackDepth)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (nd_we),
    .waddr_i(nd_wa),
    .wdata_i(nd_top_q),
    .raddr_i(nd_ra),
    .rdata_o(nd_rd)
  );

  always_comb begin
    op_cnt_d     = op_cnt_q;
    nd_cnt_d     = nd_cnt_q;
    next_node_d  = next_node_q;
    ovf_d        = ovf_q;
    res_cnt_d    = res_cnt_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    op_top_d     = op_top_q;
    nd_top_d     = nd_top_q;
    term_d       = term_q;
    pend_d       = pend_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    op_we        = 1'b0;
    nd_we        = 1'b0;
    rec_gen      = 1'b0;
    out_load     = 1'b0;
    rec          = '0;
    rec.error    = ovf_q;
    idx8         = IdxW'(next_node_q);
    node_full    = next_node_q >= NnW'(MaxNodes);

    if (cmd_i.push_term) begin
      if ((nd_cnt_q >= NcW'(NodeStackDepth)) || node_full) begin
        ovf_d = 1'b1;
      end else begin
        nd_we          = nd_cnt_q != '0;
        nd_top_d       = idx8;
        nd_cnt_d       = nd_cnt_q + NcW'(1);
        next_node_d    = next_node_q + NnW'(1);
        rec_gen        = 1'b1;
        rec.kind       = bqtb_pkg::KIND_TERM;
        rec.node_index = idx8;
        rec.term_ref   = TrW'(term_q);
      end
    end

    if (cmd_i.push_op) begin
      if (op_cnt_q >= OcW'(OpStackDepth)) begin
        ovf_d = 1'b1;
      end else begin
        op_we    = op_cnt_q != '0;
        op_top_d = cmd_i.op;
        op_cnt_d = op_cnt_q + OcW'(1);
      end
    end

    if (cmd_i.pop) begin
      op_cnt_d = op_cnt_q - OcW'(1);
      op_top_d = bqtb_pkg::opcode_e'(op_rd);
      case (op_top_q) inside
        bqtb_pkg::OP_NOT: begin
          if (nd_cnt_q != '0) begin
            if (node_full) begin
              ovf_d = 1'b1;
            end else begin
              nd_top_d        = idx8;
              next_node_d     = next_node_q + NnW'(1);
              rec_gen         = 1'b1;
              rec.kind        = bqtb_pkg::KIND_NOT;
              rec.node_index  = idx8;
              rec.right_child = nd_top_q;
            end
          end
        end
        bqtb_pkg::OP_AND, bqtb_pkg::OP_OR: begin
          if (nd_cnt_q >= NcW'(2)) begin
            if (node_full) begin
              ovf_d = 1'b1;
            end else begin
              nd_cnt_d        = nd_cnt_q - NcW'(1);
              nd_top_d        = idx8;
              next_node_d     = next_node_q + NnW'(1);
              rec_gen         = 1'b1;
              rec.kind        = (op_top_q == bqtb_pkg::OP_AND) ? bqtb_pkg::KIND_AND
                                                               : bqtb_pkg::KIND_OR;
              rec.node_index  = idx8;
              rec.left_child  = nd_rd;
              rec.right_child = nd_top_q;
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.root) begin
      rec_gen = 1'b1;
      if (nd_cnt_q != '0) begin
        rec.kind       = bqtb_pkg::KIND_ROOT;
        rec.node_index = nd_top_q;
      end else begin
        rec.kind = bqtb_pkg::KIND_EMPTY;
      end
      op_cnt_d    = '0;
      nd_cnt_d    = '0;
      next_node_d = '0;
      ovf_d       = 1'b0;
    end

    produce   = rec_gen && (res_cnt_q < RcW'(bqtb_pkg::MaxResults));
    final_rec = cmd_i.push_term || cmd_i.root;

    if (produce) begin
      res_cnt_d = res_cnt_q + RcW'(1);
      if (final_rec && !pend_valid_q) begin
        out_d       = rec;
        out_last_d  = 1'b1;
        out_valid_d = 1'b1;
        out_load    = 1'b1;
      end else begin
        if (pend_valid_q) begin
          out_d       = pend_q;
          out_last_d  = 1'b0;
          out_valid_d = 1'b1;
          out_load    = 1'b1;
        end
        pend_d       = rec;
        pend_valid_d = 1'b1;
      end
    end

    if (cmd_i.flush) begin
      out_d        = pend_q;
      out_last_d   = 1'b1;
      out_valid_d  = 1'b1;
      out_load     = 1'b1;
      pend_valid_d = 1'b0;
    end

    if (cmd_i.start) begin
      res_cnt_d = '0;
      term_d    = term_id_i[TW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_cnt_q     <= '0;
      nd_cnt_q     <= '0;
      next_node_q  <= '0;
      ovf_q        <= 1'b0;
      res_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      op_cnt_q     <= op_cnt_d;
      nd_cnt_q     <= nd_cnt_d;
      next_node_q  <= next_node_d;
      ovf_q        <= ovf_d;
      res_cnt_q    <= res_cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_top_q   <= op_top_d;
    nd_top_q   <= nd_top_d;
    term_q     <= term_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.op_nonempty = op_cnt_q != '0;
  assign sts_o.op_top      = op_top_q;
  assign sts_o.pend_valid  = pend_valid_q;
  assign sts_o.emit_ok     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_q;
  assign out_last_o  = out_last_q;

  a_flush_empties_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> !pend_valid_q)
    else $error("Hold stage still full after a flush.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("Output register loaded while a result is still waiting.");

  a_result_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= RcW'(bqtb_pkg::MaxResults))
    else $error("Result count exceeds the per-token limit.");

  a_root_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.root |=> (op_cnt_q == '0) && (nd_cnt_q == '0) && (next_node_q == '0) && !ovf_q)
    else $error("End of query did not clear the parser state.");

endmodule

// ----- design/boolean_query_tree_builder.sv -----
// Boolean query tree builder: shunting-yard parser split into a controller and a stack datapath.
// A term is pushed in ST_TERM, a NOT or left paren in ST_PUSH; an ignored token stays idle.
// AND, OR, right paren and end pop operators via ST_CHECK and ST_POP, then push
// the operator, drop the left paren or emit the root. A popped node waits in a hold stage
// until the next node or the end of its token, and a full output stalls the parser.
// Reset clears all counts, the error flag and handshake state; stack RAM contents are kept.
module boolean_query_tree_builder #(
  parameter int OpStackDepth   = bqtb_pkg::OpStackDepth,
  parameter int NodeStackDepth = bqtb_pkg::NodeStackDepth,
  parameter int MaxNodes       = bqtb_pkg::MaxNodes,
  parameter int TermIdBits     = bqtb_pkg::TermIdBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bqtb_pkg::InDataW-1:0]   s_axis_tdata,   // term_id
  input  logic [bqtb_pkg::InUserW-1:0]   s_axis_tuser,   // opcode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // node_index, term_ref, left_child, right_child
  output logic [bqtb_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [bqtb_pkg::OutUserW-1:0]  m_axis_tuser,   // kind, error
  output logic                           m_axis_tlast
);

  bqtb_pkg::cmd_t    cmd;
  bqtb_pkg::status_t sts;
  bqtb_pkg::rec_t    rec;

  bqtb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_op_i   (bqtb_pkg::opcode_e'(s_axis_tuser)),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bqtb_dpath #(
    .OpStackDepth  (OpStackDepth),
    .NodeStackDepth(NodeStackDepth),
    .MaxNodes      (MaxNodes),
    .TermIdBits    (TermIdBits)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .term_id_i  (s_axis_tdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_rec_o  (rec),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {rec.right_child, rec.left_child, rec.term_ref, rec.node_index};
  assign m_axis_tuser = {rec.error, rec.kind};

endmodule

// ----- tb/query_tree_checker.sv -----
// Checker that predicts the query tree node records and compares them with the output stream.
module query_tree_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [bqtb_pkg::InDataW-1:0]  s_tdata_i,   // term_id
  input  logic [bqtb_pkg::InUserW-1:0]  s_tuser_i,   // opcode
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  // node_index, term_ref, left_child, right_child
  input  logic [bqtb_pkg::OutDataW-1:0] m_tdata_i,
  input  logic [bqtb_pkg::OutUserW-1:0] m_tuser_i,   // kind, error
  input  logic                          m_tlast_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TrW  = bqtb_pkg::TermRefW;
  localparam int IdxW = bqtb_pkg::NodeIdxW;
  localparam int KW   = bqtb_pkg::KindW;

  localparam logic [TrW-1:0] TermMask = TrW'((64'd1 << bqtb_pkg::TermIdBits) - 64'd1);

  typedef struct {
    bqtb_pkg::kind_e kind;
    logic [IdxW-1:0] node_index;
    logic [TrW-1:0]  term_ref;
    logic [IdxW-1:0] left_child;
    logic [IdxW-1:0] right_child;
    logic            error;
    logic            last;
  } node_rec_t;

  bqtb_pkg::opcode_e pend_ops [bqtb_pkg::OpStackDepth];
  int                op_cnt = 0;
  int                tree_ids [bqtb_pkg::NodeStackDepth];
  int                tree_cnt = 0;
  int                next_id = 0;
  logic              query_overflow = 1'b0;
  node_rec_t         step_recs[$];
  node_rec_t         expected_nodes[$];
  int                mismatches = 0;
  int                records_seen = 0;

  function automatic int op_rank(bqtb_pkg::opcode_e op);
    case (op)
      bqtb_pkg::OP_NOT: return 3;
      bqtb_pkg::OP_AND: return 2;
      bqtb_pkg::OP_OR:  return 1;
      default:          return 0;
    endcase
  endfunction

  function automatic void add_node_rec(bqtb_pkg::kind_e kind, int idx, logic [TrW-1:0] tref,
                                       int lch, int rch);
    node_rec_t rec;
    if (step_recs.size() >= bqtb_pkg::MaxResults) return;
    rec.kind        = kind;
    rec.node_index  = IdxW'(idx);
    rec.term_ref    = tref;
    rec.left_child  = IdxW'(lch);
    rec.right_child = IdxW'(rch);
    rec.error       = query_overflow;
    rec.last        = 1'b0;
    step_recs.push_back(rec);
  endfunction

  function automatic void stack_op(bqtb_pkg::opcode_e op);
    if (op_cnt >= bqtb_pkg::OpStackDepth) begin
      query_overflow = 1'b1;
      return;
    end
    pend_ops[op_cnt] = op;
    op_cnt++;
  endfunction

  // Pops the top operator and, if it has the subtrees it needs, combines them into a new node.
  function automatic void reduce_top();
    bqtb_pkg::opcode_e op;
    int                lch;
    int                rch;
    int                idx;
    if (op_cnt == 0) return;
    op_cnt--;
    op = pend_ops[op_cnt];
    if (op == bqtb_pkg::OP_NOT) begin
      if (tree_cnt < 1) return;
      if (next_id >= bqtb_pkg::MaxNodes) begin
        query_overflow = 1'b1;
        return;
      end
      rch = tree_ids[tree_cnt-1];
      idx = next_id;
      next_id++;
      tree_ids[tree_cnt-1] = idx;
      add_node_rec(bqtb_pkg::KIND_NOT, idx, '0, 0, rch);
      return;
    end
    if (op != bqtb_pkg::OP_AND && op != bqtb_pkg::OP_OR) return;
    if (tree_cnt < 2) return;
    if (next_id >= bqtb_pkg::MaxNodes) begin
      query_overflow = 1'b1;
      return;
    end
    rch = tree_ids[tree_cnt-1];
    lch = tree_ids[tree_cnt-2];
    idx = next_id;
    next_id++;
    tree_cnt--;
    tree_ids[tree_cnt-1] = idx;
    add_node_rec((op == bqtb_pkg::OP_AND) ? bqtb_pkg::KIND_AND : bqtb_pkg::KIND_OR,
                 idx, '0, lch, rch);
  endfunction

  function automatic void predict_token(bqtb_pkg::opcode_e op,
                                        logic [bqtb_pkg::InDataW-1:0] tid);
    int idx;
    case (op)
      bqtb_pkg::OP_TERM: begin
        if (tree_cnt >= bqtb_pkg::NodeStackDepth || next_id >= bqtb_pkg::MaxNodes) begin
          query_overflow = 1'b1;
        end else begin
          idx = next_id;
          next_id++;
          tree_ids[tree_cnt] = idx;
          tree_cnt++;
          add_node_rec(bqtb_pkg::KIND_TERM, idx, TrW'(tid) & TermMask, 0, 0);
        end
      end
      bqtb_pkg::OP_AND, bqtb_pkg::OP_OR: begin
        while (op_cnt > 0 && pend_ops[op_cnt-1] != bqtb_pkg::OP_LPAREN &&
               op_rank(pend_ops[op_cnt-1]) >= op_rank(op))
          reduce_top();
        stack_op(op);
      end
      bqtb_pkg::OP_NOT, bqtb_pkg::OP_LPAREN: begin
        stack_op(op);
      end
      bqtb_pkg::OP_RPAREN: begin
        while (op_cnt > 0 && pend_ops[op_cnt-1] != bqtb_pkg::OP_LPAREN)
          reduce_top();
        if (op_cnt > 0) op_cnt--;
      end
      bqtb_pkg::OP_END: begin
        while (op_cnt > 0) begin
          if (pend_ops[op_cnt-1] == bqtb_pkg::OP_LPAREN) op_cnt--;
          else reduce_top();
        end
        if (tree_cnt > 0) add_node_rec(bqtb_pkg::KIND_ROOT, tree_ids[tree_cnt-1], '0, 0, 0);
        else add_node_rec(bqtb_pkg::KIND_EMPTY, 0, '0, 0, 0);
        op_cnt         = 0;
        tree_cnt       = 0;
        next_id        = 0;
        query_overflow = 1'b0;
      end
      default: begin
      end
    endcase
    if (step_recs.size() > 0) step_recs[step_recs.size()-1].last = 1'b1;
    foreach (step_recs[i]) expected_nodes.push_back(step_recs[i]);
    step_recs.delete();
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      note_mismatch($sformatf("record %0d %s: got %0d, expected %0d",
                              records_seen, name, got, want));
  endtask

  task automatic check_record();
    node_rec_t want;
    if (expected_nodes.size() == 0) begin
      note_mismatch($sformatf("record %0d arrived with nothing expected (kind %0d index %0d)",
                              records_seen, m_tuser_i[KW-1:0], m_tdata_i[7:0]));
      records_seen++;
      return;
    end
    want = expected_nodes.pop_front();
    check_field("kind", 32'(m_tuser_i[KW-1:0]), 32'(want.kind));
    check_field("node_index", 32'(m_tdata_i[7:0]), 32'(want.node_index));
    check_field("term_ref", 32'(m_tdata_i[23:8]), 32'(want.term_ref));
    check_field("left_child", 32'(m_tdata_i[31:24]), 32'(want.left_child));
    check_field("right_child", 32'(m_tdata_i[39:32]), 32'(want.right_child));
    check_field("error", 32'(m_tuser_i[KW]), 32'(want.error));
    check_field("last", 32'(m_tlast_i), 32'(want.last));
    records_seen++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) predict_token(bqtb_pkg::opcode_e'(s_tuser_i), s_tdata_i);
      if (m_tvalid_i && m_tready_i) check_record();
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_nodes.size();
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top: drives query token streams into the tree builder and reports the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int InW = bqtb_pkg::InDataW;

  typedef struct {
    bqtb_pkg::opcode_e op;
    logic [InW-1:0]    tid;
  } token_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [InW-1:0]                s_tdata = '0;
  logic [bqtb_pkg::InUserW-1:0]  s_tuser = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [bqtb_pkg::OutDataW-1:0] m_tdata;
  logic [bqtb_pkg::OutUserW-1:0] m_tuser;
  logic                          m_tlast;
  logic                          steady = 1'b0;
  int                            fail_count;
  int                            pending;

  token_t token_q[$];
  int     tokens_sent = 0;
  int     queries_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  boolean_query_tree_builder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  query_tree_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= 10);
    end
  end

  function automatic logic [InW-1:0] random_term_id();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return InW'($urandom);
    endcase
  endfunction

  task automatic push_tok(input bqtb_pkg::opcode_e op);
    token_t t;
    t.op  = op;
    t.tid = random_term_id();
    token_q.push_back(t);
  endtask

  task automatic push_term(input logic [InW-1:0] tid);
    token_t t;
    t.op  = bqtb_pkg::OP_TERM;
    t.tid = tid;
    token_q.push_back(t);
  endtask

  task automatic send_token(input token_t t);
    while (!steady && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= t.op;
    s_tdata  <= t.tid;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tokens_sent++;
  endtask

  task automatic send_queue();
    foreach (token_q[i]) send_token(token_q[i]);
    token_q.delete();
    queries_sent++;
  endtask

  // Well-formed infix query with random nesting, occasionally damaged by noise.
  task automatic build_random_query();
    int     n_terms;
    int     open_parens;
    int     spots;
    int     pos;
    token_t t;
    n_terms = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
    open_parens = 0;
    for (int k = 0; k < n_terms; k++) begin
      while ($urandom_range(0, 99) < 25) begin
        if ($urandom_range(0, 1) == 0) begin
          push_tok(bqtb_pkg::OP_NOT);
        end else begin
          push_tok(bqtb_pkg::OP_LPAREN);
          open_parens++;
        end
      end
      push_term(random_term_id());
      while (open_parens > 0 && $urandom_range(0, 99) < 35) begin
        push_tok(bqtb_pkg::OP_RPAREN);
        open_parens--;
      end
      if (k != n_terms - 1) push_tok($urandom_range(0, 1) ? bqtb_pkg::OP_AND : bqtb_pkg::OP_OR);
    end
    while (open_parens > 0) begin
      push_tok(bqtb_pkg::OP_RPAREN);
      open_parens--;
    end
    if ($urandom_range(0, 99) < 20) begin
      spots = $urandom_range(1, 3);
      for (int k = 0; k < spots; k++) begin
        pos   = $urandom_range(0, token_q.size() - 1);
        t.op  = bqtb_pkg::opcode_e'($urandom_range(0, 7));
        t.tid = random_term_id();
        case ($urandom_range(0, 2))
          0:       if (token_q.size() > 1) token_q.delete(pos);
          1:       token_q.insert(pos, t);
          default: begin
            t.op = bqtb_pkg::OP_IGNORE;
            token_q.insert(pos, t);
          end
        endcase
      end
    end
    push_tok(bqtb_pkg::OP_END);
  endtask

  initial begin
    int random_items;
    int wait_cycles;
    random_items = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty query, both term extremes, precedence, parens, missing operands,
    // a right paren with no left paren and an ignored token.
    push_tok(bqtb_pkg::OP_END);
    push_term('0);
    push_tok(bqtb_pkg::OP_AND);
    push_term('1);
    push_tok(bqtb_pkg::OP_END);
    push_term('1);
    push_tok(bqtb_pkg::OP_OR);
    push_tok(bqtb_pkg::OP_NOT);
    push_term('0);
    push_tok(bqtb_pkg::OP_END);
    push_tok(bqtb_pkg::OP_LPAREN);
    push_term(random_term_id());
    push_tok(bqtb_pkg::OP_OR);
    push_term(random_term_id());
    push_tok(bqtb_pkg::OP_RPAREN);
    push_tok(bqtb_pkg::OP_AND);
    push_term(random_term_id());
    push_tok(bqtb_pkg::OP_END);
    push_tok(bqtb_pkg::OP_AND);
    push_term(random_term_id());
    push_tok(bqtb_pkg::OP_RPAREN);
    push_tok(bqtb_pkg::OP_IGNORE);
    push_tok(bqtb_pkg::OP_END);
    push_tok(bqtb_pkg::OP_NOT);
    push_tok(bqtb_pkg::OP_END);
    send_queue();

    // Operator stack full of left parens, then an AND that finds no room.
    repeat (bqtb_pkg::OpStackDepth) push_tok(bqtb_pkg::OP_LPAREN);
    push_term(random_term_id());
    push_tok(bqtb_pkg::OP_AND);
    push_term(random_term_id());
    push_tok(bqtb_pkg::OP_RPAREN);
    push_tok(bqtb_pkg::OP_END);
    send_queue();

    // A NOT chain one deeper than the stack gives the longest burst of records.
    repeat (bqtb_pkg::OpStackDepth + 1) push_tok(bqtb_pkg::OP_NOT);
    push_term(random_term_id());
    push_tok(bqtb_pkg::OP_END);
    send_queue();

    // More terms than the node stack holds.
    repeat (bqtb_pkg::NodeStackDepth + 2) push_term(random_term_id());
    push_tok(bqtb_pkg::OP_OR);
    push_tok(bqtb_pkg::OP_END);
    send_queue();

    while (random_items < 110) begin
      steady <= (random_items >= 30 && random_items < 80);
      build_random_query();
      foreach (token_q[i]) if (token_q[i].op != bqtb_pkg::OP_IGNORE) random_items++;
      send_queue();
    end
    steady   <= 1'b0;
    s_tvalid <= 1'b0;
    @(posedge clk);

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);

    $display("Sent %0d tokens in %0d queries: directed cases, operator and node stack overflow,",
             tokens_sent, queries_sent);
    $display("and random nested queries with noise; %0d records still expected at the end.",
             pending);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d records still expected.", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- boolean_query_tree_builder.f -----
design/bqtb_pkg.sv
design/bqtb_ram.sv
design/bqtb_ctrl.sv
design/bqtb_dpath.sv
design/boolean_query_tree_builder.sv
tb/query_tree_checker.sv
tb/tb.sv
